### rtl/gpio_pad_direction_model_assert.svh
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GPIO_PAD_DIRECTION_MODEL_ASSERT_SVH
`define GPIO_PAD_DIRECTION_MODEL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpd assertion failed");

`endif

### rtl/gpd_pkg.sv
// ----------------------------------------------------------------------------
// gpd_pkg
// Shared types, codes and constants of the GPIO pad direction model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gpd_pkg;

  // Field widths fixed by the interface.
  localparam int PIN_W   = 6;
  localparam int CMD_W   = 2;
  localparam int DIR_W   = 2;
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 2;

  // Default pin count and output-capable mask register.
  localparam int              PIN_COUNT_DEF = 40;
  localparam int              CAP_BITS      = 40;
  localparam logic [CAP_BITS-1:0] CAP_RESET  = 40'h03_FFFF_FFFF;

  // Configuration port geometry: one 64-bit register at byte address 0.
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 64;
  localparam int REG_IDX_W = APB_AW - 3;
  localparam logic [REG_IDX_W-1:0] REG_CAP_MASK = '0;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_SET_DIR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 2'd1;
  localparam logic [CMD_W-1:0] CMD_HOST      = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY     = 2'd3;

  // Pin directions.
  localparam logic [DIR_W-1:0] DIR_UNCONF = 2'd0;
  localparam logic [DIR_W-1:0] DIR_INPUT  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_OUTPUT = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RSVD   = 2'd3;

  // Record kinds.
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEVEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DIR   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_VIOL  = 2'd3;

  // Direction report values.
  localparam logic [VALUE_W-1:0] DREP_INPUT  = 2'd0;
  localparam logic [VALUE_W-1:0] DREP_OUTPUT = 2'd1;

  // Violation causes.
  localparam logic [VALUE_W-1:0] VIOL_HOST_ON_OUTPUT = 2'd0;
  localparam logic [VALUE_W-1:0] VIOL_NOT_CAPABLE    = 2'd1;
  localparam logic [VALUE_W-1:0] VIOL_HOST_ON_UNCONF = 2'd2;

  // One stored pin entry.
  typedef struct packed {
    logic [DIR_W-1:0] dir;
    logic             level;
    logic             latch;
  } entry_t;

  // One result record.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PIN_W-1:0]   pin;
    logic [VALUE_W-1:0] value;
    logic               line_level;
    logic               tracked;
    logic               last;
  } record_t;

  // Outcome of one command: write-back and up to two records.
  typedef struct packed {
    logic       we;
    entry_t     wdata;
    logic [1:0] count;
    record_t    rec0;
    record_t    rec1;
  } decision_t;

endpackage

### rtl/gpd_in_if.sv
// ----------------------------------------------------------------------------
// gpd_in_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpd_in_if;
  import gpd_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [PIN_W-1:0]   pin;
  logic [DIR_W-1:0]   direction;
  logic               level_in;

  modport source (output valid, output cmd, output pin, output direction,
                  output level_in, input ready);
  modport sink   (input valid, input cmd, input pin, input direction,
                  input level_in, output ready);
endinterface

### rtl/gpd_out_if.sv
// ----------------------------------------------------------------------------
// gpd_out_if
// Result channel: valid/ready handshake with one result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gpd_out_if;
  import gpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   record_kind;
  logic [PIN_W-1:0]    pin_out;
  logic [VALUE_W-1:0]  value;
  logic                line_level;
  logic                tracked;
  logic                last;

  modport source (output valid, output record_kind, output pin_out, output value,
                  output line_level, output tracked, output last, input ready);
  modport sink   (input valid, input record_kind, input pin_out, input value,
                  input line_level, input tracked, input last, output ready);
endinterface

### rtl/gpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// gpd_cfg_regs
// Configuration register file holding the output-capable pad mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpd_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpd_pkg::APB_AW-1:0]  paddr,
  input  logic [gpd_pkg::APB_DW-1:0]  pwdata,
  output logic [gpd_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [gpd_pkg::CAP_BITS-1:0] cap_mask
);
  import gpd_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_hit;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[APB_AW-1:3];
  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_CAP_MASK);

  // Mask register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_mask <= CAP_RESET;
    end else if (wr_hit) begin
      cap_mask <= pwdata[CAP_BITS-1:0];
    end
  end

  // Read back.
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAP_MASK) begin
      prdata = {{(APB_DW-CAP_BITS){1'b0}}, cap_mask};
    end
  end
endmodule

### rtl/gpd_state_mem.sv
// ----------------------------------------------------------------------------
// gpd_state_mem
// Per-pin state memory with registered read and per-entry valid
// bits; an entry never written reads as the reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpd_state_mem #(
  parameter int DEPTH = gpd_pkg::PIN_COUNT_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output gpd_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  gpd_pkg::entry_t wr_data
);
  import gpd_pkg::*;

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   written;
  entry_t             rd_q;
  logic               rd_vld_q;

  // Storage write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Valid bits, cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= written[rd_addr];
      end
    end
  end

  // An unwritten entry reads as unconfigured, low level, low latch.
  assign rd_data = rd_vld_q ? rd_q : '0;
endmodule

### rtl/gpd_pin_logic.sv
// ----------------------------------------------------------------------------
// gpd_pin_logic
// Decides the new pin entry and the result records for one command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gpd_pin_logic (
  input  logic [gpd_pkg::CMD_W-1:0] cmd,
  input  logic [gpd_pkg::PIN_W-1:0] pin,
  input  logic [gpd_pkg::DIR_W-1:0] direction,
  input  logic                      level_in,
  input  logic                      in_range,
  input  logic                      capable,
  input  gpd_pkg::entry_t           entry,
  output gpd_pkg::decision_t        dec
);
  import gpd_pkg::*;

  record_t base;

  // Common record fields: the pin, and zero elsewhere.
  always_comb begin
    base      = '0;
    base.pin  = pin;
  end

  always_comb begin
    dec       = '0;
    dec.wdata = entry;
    dec.rec0  = base;
    dec.rec1  = base;

    if (!in_range) begin
      // Out-of-range pin: only a query answers, with zero value, level and tracking.
      if (cmd == CMD_QUERY) begin
        dec.count     = 2'd1;
        dec.rec0.kind = KIND_QUERY;
      end
    end else begin
      case (cmd)
        CMD_SET_DIR: begin
          if (direction == DIR_RSVD) begin
            dec.count = 2'd0;
          end else if (direction == DIR_OUTPUT && !capable) begin
            dec.count      = 2'd1;
            dec.rec0.kind  = KIND_VIOL;
            dec.rec0.value = VIOL_NOT_CAPABLE;
          end else if (entry.dir != direction) begin
            dec.we        = 1'b1;
            dec.wdata.dir = direction;
            if (direction == DIR_INPUT) begin
              // Input forces the line high and always reports it.
              dec.count       = 2'd2;
              dec.wdata.level = 1'b1;
              dec.rec0.kind   = KIND_DIR;
              dec.rec0.value  = DREP_INPUT;
              dec.rec1.kind   = KIND_LEVEL;
              dec.rec1.value  = 2'd1;
            end else if (direction == DIR_OUTPUT) begin
              // Output drives the latch onto the line.
              dec.rec0.kind  = KIND_DIR;
              dec.rec0.value = DREP_OUTPUT;
              if (entry.level != entry.latch) begin
                dec.count       = 2'd2;
                dec.wdata.level = entry.latch;
                dec.rec1.kind   = KIND_LEVEL;
                dec.rec1.value  = {1'b0, entry.latch};
              end else begin
                dec.count = 2'd1;
              end
            end
          end
        end
        CMD_SET_LEVEL: begin
          dec.we          = 1'b1;
          dec.wdata.latch = level_in;
          if (entry.dir == DIR_OUTPUT && entry.level != level_in) begin
            dec.count       = 2'd1;
            dec.wdata.level = level_in;
            dec.rec0.kind   = KIND_LEVEL;
            dec.rec0.value  = {1'b0, level_in};
          end
        end
        CMD_HOST: begin
          if (entry.dir == DIR_INPUT) begin
            if (entry.level != level_in) begin
              dec.we          = 1'b1;
              dec.count       = 2'd1;
              dec.wdata.level = level_in;
              dec.rec0.kind   = KIND_LEVEL;
              dec.rec0.value  = {1'b0, level_in};
            end
          end else if (entry.dir == DIR_OUTPUT) begin
            dec.count      = 2'd1;
            dec.rec0.kind  = KIND_VIOL;
            dec.rec0.value = VIOL_HOST_ON_OUTPUT;
          end else begin
            dec.count      = 2'd1;
            dec.rec0.kind  = KIND_VIOL;
            dec.rec0.value = VIOL_HOST_ON_UNCONF;
          end
        end
        default: begin
          // Query.
          dec.count           = 2'd1;
          dec.rec0.kind       = KIND_QUERY;
          dec.rec0.value      = {1'b0, entry.level};
          dec.rec0.line_level = entry.level;
          dec.rec0.tracked    = (entry.dir != DIR_UNCONF);
        end
      endcase
    end

    // Mark the final record of this command.
    dec.rec0.last = (dec.count == 2'd1);
    dec.rec1.last = 1'b1;
  end
endmodule

### rtl/gpio_pad_direction_model.sv
// ----------------------------------------------------------------------------
// gpio_pad_direction_model
// Per-pin GPIO pad model: directions, line levels and output latches kept in
// a state memory, updated by firmware and host commands, with result records.
// ----------------------------------------------------------------------------
// Sequence: the state memory is read at the edge that accepts a command, and
//   the decision loads the result buffer once the buffer has room; results
//   are then offered from the buffer.
// Flow: a command is accepted only once the last one is decided; a stalled
//   result channel holds the decide step until the buffer has room.
// Reset: synchronous, active high; clears control state, the memory valid
//   bits (all pins read as unconfigured, low) and loads the mask default.
`timescale 1ns / 1ps

module gpio_pad_direction_model #(
  parameter int PIN_COUNT = gpd_pkg::PIN_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  gpd_in_if.sink                       request,
  gpd_out_if.source                    result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gpd_pkg::APB_AW-1:0]   paddr,
  input  logic [gpd_pkg::APB_DW-1:0]   pwdata,
  output logic [gpd_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import gpd_pkg::*;

  localparam int AW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                state;
  logic [CMD_W-1:0]    cmd_q;
  logic [PIN_W-1:0]    pin_q;
  logic [DIR_W-1:0]    dir_q;
  logic                lvl_q;
  logic                range_q;

  logic [CAP_BITS-1:0]     cap_mask;
  logic [(2**PIN_W)-1:0]   cap_ext;
  logic                    capable;
  logic                    in_range;
  logic                    in_fire;
  logic                    out_fire;
  logic                    buf_free;
  logic                    exec_go;
  entry_t                  rd_entry;
  decision_t               dec;

  record_t    buf0;
  record_t    buf1;
  logic [1:0] buf_cnt;

  // Configuration registers.
  gpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cap_mask (cap_mask)
  );

  // Handshakes.
  assign request.ready = (state == ST_IDLE);
  assign in_fire       = request.valid && request.ready;
  assign out_fire      = result.valid && result.ready;
  assign in_range      = ({1'b0, request.pin} < (PIN_W+1)'(PIN_COUNT));

  // The buffer can take new records when it is empty after this cycle.
  assign buf_free = (buf_cnt == 2'd0) || (buf_cnt == 2'd1 && out_fire);
  assign exec_go  = (state == ST_EXEC) && buf_free;

  // Sequencer: capture a command, then decide once the buffer has room.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (buf_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q   <= request.cmd;
      pin_q   <= request.pin;
      dir_q   <= request.direction;
      lvl_q   <= request.level_in;
      range_q <= in_range;
    end
  end

  // Per-pin state memory; the read is issued with the transfer itself.
  gpd_state_mem #(
    .DEPTH (PIN_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire && in_range),
    .rd_addr (request.pin[AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (exec_go && range_q && dec.we),
    .wr_addr (pin_q[AW-1:0]),
    .wr_data (dec.wdata)
  );

  // Pins beyond the mask width are never output capable.
  assign cap_ext = {{((2**PIN_W)-CAP_BITS){1'b0}}, cap_mask};
  assign capable = cap_ext[pin_q];

  gpd_pin_logic u_logic (
    .cmd       (cmd_q),
    .pin       (pin_q),
    .direction (dir_q),
    .level_in  (lvl_q),
    .in_range  (range_q),
    .capable   (capable),
    .entry     (rd_entry),
    .dec       (dec)
  );

  // Two-entry result buffer; a load always finds it drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 2'd0;
    end else if (exec_go) begin
      buf_cnt <= dec.count;
    end else if (out_fire) begin
      buf_cnt <= buf_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      buf0 <= dec.rec0;
      buf1 <= dec.rec1;
    end else if (out_fire) begin
      buf0 <= buf1;
    end
  end

  // Result channel.
  assign result.valid       = (buf_cnt != 2'd0);
  assign result.record_kind = buf0.kind;
  assign result.pin_out     = buf0.pin;
  assign result.value       = buf0.value;
  assign result.line_level  = buf0.line_level;
  assign result.tracked     = buf0.tracked;
  assign result.last        = buf0.last;
endmodule

### rtl/gpd_checker.sv
// ----------------------------------------------------------------------------
// gpd_checker
// Port-level checks on the result channel of the pad model, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gpio_pad_direction_model_assert.svh"

module gpd_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [gpd_pkg::KIND_W-1:0]   res_kind,
  input logic [gpd_pkg::PIN_W-1:0]    res_pin,
  input logic [gpd_pkg::VALUE_W-1:0]  res_value,
  input logic                         res_line,
  input logic                         res_tracked,
  input logic                         res_last
);
  import gpd_pkg::*;

  // A stalled record holds its payload.
  `GPD_ASSERT_NEXT(a_hold, res_valid && !res_ready, res_valid && $stable({res_kind, res_pin, res_value, res_line, res_tracked, res_last}))

  // After a non-final record leaves, the next record of its command is already valid.
  `GPD_ASSERT_NEXT(a_burst, res_valid && res_ready && !res_last, res_valid)

  // A query reply and a violation are single records.
  `GPD_ASSERT_NOW(a_single, res_valid && (res_kind == KIND_QUERY || res_kind == KIND_VIOL), res_last)

  // Line level and tracking are only reported in a query reply.
  `GPD_ASSERT_NOW(a_quiet, res_valid && res_kind != KIND_QUERY, !res_line && !res_tracked)
endmodule

bind gpio_pad_direction_model gpd_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_kind    (result.record_kind),
  .res_pin     (result.pin_out),
  .res_value   (result.value),
  .res_line    (result.line_level),
  .res_tracked (result.tracked),
  .res_last    (result.last)
);
